// ----- rtl/core/set_assoc_lru_writeback_cache_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Cache unit assertion macros
// Concurrent assertion shorthands clocked on the rising edge and disabled
// while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_WRITEBACK_CACHE_UNIT_ASSERT_SVH
`define SET_ASSOC_LRU_WRITEBACK_CACHE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SACACHE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SACACHE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/sacache_pkg.sv -----
// ----------------------------------------------------------------------------
// Cache unit package
// Geometry constants, action codes and the per-set directory row type.
// ----------------------------------------------------------------------------
`default_nettype none

package sacache_pkg;

  localparam int unsigned SetCount        = 64;
  localparam int unsigned WayCount        = 4;
  localparam int unsigned BlockOffsetBits = 6;
  localparam int unsigned AddrW           = 32;

  localparam int unsigned SetW    = $clog2(SetCount);
  localparam int unsigned TagW    = AddrW - BlockOffsetBits - SetW;
  localparam int unsigned WayW    = (WayCount > 1) ? $clog2(WayCount) : 1;
  localparam int unsigned LruW    = WayW;
  localparam int unsigned ActionW = 2;
  localparam int unsigned OutWayW = 2;

  localparam logic [LruW-1:0] LruMax = LruW'(WayCount - 1);

  typedef enum logic [ActionW-1:0] {
    ActRead  = 2'd0,
    ActWrite = 2'd1,
    ActInval = 2'd2
  } action_e;

  // One directory row holds the whole set.
  typedef struct packed {
    logic [WayCount-1:0][TagW-1:0] tag;
    logic [WayCount-1:0]           valid;
    logic [WayCount-1:0]           dirty;
    logic [WayCount-1:0][LruW-1:0] lru;
  } set_row_t;

endpackage

`default_nettype wire

// ----- rtl/core/sacache_req_if.sv -----
// ----------------------------------------------------------------------------
// Cache request channel
// Valid/ready channel carrying an address and an action code.
// ----------------------------------------------------------------------------
`default_nettype none

interface sacache_req_if import sacache_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [AddrW-1:0]   address;
  logic [ActionW-1:0] action;

  modport source (output valid, output address, output action, input ready);
  modport sink   (input valid, input address, input action, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sacache_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Cache response channel
// Valid/ready channel carrying hit, write-back and way of one request.
// ----------------------------------------------------------------------------
`default_nettype none

interface sacache_rsp_if import sacache_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               hit;
  logic               write_back;
  logic [OutWayW-1:0] way;

  modport source (output valid, output hit, output write_back, output way, input ready);
  modport sink   (input valid, input hit, input write_back, input way, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/set_assoc_lru_writeback_cache_unit.sv -----
// ----------------------------------------------------------------------------
// Set-associative LRU write-back cache directory
// Tag/state lookup and update for read, write and snoop invalidate requests.
// ----------------------------------------------------------------------------
//  channel | dir | fields                   | handshake
//  req_i   | in  | address, action          | valid/ready
//  rsp_o   | out | hit, write_back, way     | valid/ready
//
//  One request per cycle sustained while rsp_o is not stalled. The set row
//  RAM (one read and one write port, read data registered) feeds the request
//  stage; a same-set write is forwarded to the read.
//  Reset clears one init flag per set at once, so there is no clearing pass.
//  A stalled response holds the request stage; req_i.ready drops only when
//  both stages are full and rsp_o is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "set_assoc_lru_writeback_cache_unit_assert.svh"

module set_assoc_lru_writeback_cache_unit import sacache_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sacache_req_if.sink   req_i,
  sacache_rsp_if.source rsp_o
);

  logic               accept;
  logic               adv;
  logic [SetW-1:0]    in_set;
  logic [TagW-1:0]    in_tag;

  logic               a_valid_q;
  logic [SetW-1:0]    a_set_q;
  logic [TagW-1:0]    a_tag_q;
  logic [ActionW-1:0] a_action_q;

  set_row_t           row_mem_q [SetCount];
  logic [SetCount-1:0] row_init_q;
  set_row_t           rd_row_q;
  set_row_t           byp_row_q;
  logic               byp_q;
  logic               rd_init_q;

  set_row_t           cur_row;
  set_row_t           wr_row;
  logic [WayCount-1:0] hit_vec;
  logic               found;
  logic [WayW-1:0]    hit_way;
  logic [WayW-1:0]    free_way;
  logic [WayW-1:0]    lru_way;
  logic [LruW-1:0]    best_age;
  logic [WayW-1:0]    victim;
  logic [WayW-1:0]    touch_way;
  logic [LruW-1:0]    old_age;
  logic [WayCount-1:0][LruW-1:0] touched_lru;
  logic [WayCount-1:0] mru_vec;

  logic               res_hit;
  logic               res_wb;
  logic [WayW-1:0]    res_way;

  logic               o_valid_q;
  logic               o_hit_q;
  logic               o_wb_q;
  logic [OutWayW-1:0] o_way_q;

  assign in_set = req_i.address[BlockOffsetBits +: SetW];
  assign in_tag = req_i.address[AddrW-1 -: TagW];

  assign adv         = a_valid_q && (!o_valid_q || rsp_o.ready);
  assign req_i.ready = !a_valid_q || adv;
  assign accept      = req_i.valid && req_i.ready;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      o_valid_q  <= 1'b0;
      row_init_q <= '0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (adv) begin
        a_valid_q <= 1'b0;
      end
      if (adv) begin
        o_valid_q           <= 1'b1;
        row_init_q[a_set_q] <= 1'b1;
      end else if (rsp_o.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // Set row RAM
  always_ff @(posedge clk_i) begin
    if (adv) begin
      row_mem_q[a_set_q] <= wr_row;
    end
    if (accept) begin
      rd_row_q <= row_mem_q[in_set];
    end
  end

  // Request stage payload and write forwarding
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_set_q    <= in_set;
      a_tag_q    <= in_tag;
      a_action_q <= req_i.action;
      rd_init_q  <= row_init_q[in_set];
      byp_q      <= adv && (a_set_q == in_set);
      byp_row_q  <= wr_row;
    end
  end

  // A set never written reads as all invalid with zero ages.
  assign cur_row = byp_q ? byp_row_q : (rd_init_q ? rd_row_q : '0);

  always_comb begin
    for (int j = 0; j < WayCount; j++) begin
      hit_vec[j] = cur_row.valid[j] && (cur_row.tag[j] == a_tag_q);
    end
    found = |hit_vec;

    hit_way  = '0;
    free_way = '0;
    for (int j = WayCount - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_way = WayW'(j);
      end
      if (!cur_row.valid[j]) begin
        free_way = WayW'(j);
      end
    end

    // Oldest way; on equal ages the higher way wins.
    best_age = '0;
    lru_way  = '0;
    for (int j = 0; j < WayCount; j++) begin
      if (cur_row.lru[j] >= best_age) begin
        best_age = cur_row.lru[j];
        lru_way  = WayW'(j);
      end
    end
    victim = (&cur_row.valid) ? lru_way : free_way;

    touch_way = found ? hit_way : victim;
    old_age   = cur_row.lru[touch_way];
    for (int j = 0; j < WayCount; j++) begin
      if (WayW'(j) == touch_way) begin
        touched_lru[j] = '0;
      end else if (cur_row.lru[j] <= old_age && cur_row.lru[j] < LruMax) begin
        touched_lru[j] = cur_row.lru[j] + 1'b1;
      end else begin
        touched_lru[j] = cur_row.lru[j];
      end
    end

    wr_row  = cur_row;
    res_hit = 1'b0;
    res_wb  = 1'b0;
    res_way = '0;
    if (a_action_q == ActInval) begin
      if (found) begin
        res_hit                = 1'b1;
        res_wb                 = cur_row.dirty[hit_way];
        res_way                = hit_way;
        wr_row.valid[hit_way]  = 1'b0;
        wr_row.dirty[hit_way]  = 1'b0;
      end
    end else if (found) begin
      res_hit    = 1'b1;
      res_way    = hit_way;
      wr_row.lru = touched_lru;
      if (a_action_q == ActWrite) begin
        wr_row.dirty[hit_way] = 1'b1;
      end
    end else begin
      res_way              = victim;
      res_wb               = cur_row.valid[victim] && cur_row.dirty[victim];
      wr_row.lru           = touched_lru;
      wr_row.tag[victim]   = a_tag_q;
      wr_row.valid[victim] = 1'b1;
      wr_row.dirty[victim] = (a_action_q == ActWrite);
    end

    for (int j = 0; j < WayCount; j++) begin
      mru_vec[j] = wr_row.valid[j] && (wr_row.lru[j] == '0);
    end
  end

  // Response register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_hit_q <= res_hit;
      o_wb_q  <= res_wb;
      o_way_q <= OutWayW'(res_way);
    end
  end

  assign rsp_o.valid      = o_valid_q;
  assign rsp_o.hit        = o_hit_q;
  assign rsp_o.write_back = o_wb_q;
  assign rsp_o.way        = o_way_q;

  // A tag is present in at most one valid way of a set.
  `SACACHE_ASSERT_IMPL(a_tag_unique, clk_i, rst_ni, adv, $onehot0(hit_vec), "tag hit in several ways")
  // Only one valid way of a set can be most recently used.
  `SACACHE_ASSERT_IMPL(a_mru_unique, clk_i, rst_ni, adv, $onehot0(mru_vec), "several MRU ways")
  // A miss evicts a dirty line only from a full set.
  `SACACHE_ASSERT_IMPL(a_wb_full, clk_i, rst_ni, adv && !found && (a_action_q != ActInval) && res_wb, &cur_row.valid, "eviction from set with a free way")
  // A stalled request stage keeps its request.
  `SACACHE_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, a_valid_q && !adv, a_valid_q && $stable(a_tag_q) && $stable(a_set_q), "request stage lost while stalled")

endmodule

`default_nettype wire
